/* sv/quadrature_detent_position_counter_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature detent position counter
// Implication checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_POSITION_COUNTER_TOP_MACROS_SVH
`define QUADRATURE_DETENT_POSITION_COUNTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QDPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define QDPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QDPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define QDPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/qdpc_pkg.sv */
// ----------------------------------------------------------------------------
// qdpc_pkg
// Shared types, register map and decode constants of the detent counter
// ----------------------------------------------------------------------------
package qdpc_pkg;

    // register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_MIN_VALUE      = 3'd0,
        REG_STEP_SIZE      = 3'd1,
        REG_N_STEPS        = 3'd2,
        REG_INVERT         = 3'd3,
        REG_WRAP_AROUND    = 3'd4,
        REG_START_POSITION = 3'd5
    } qdpc_reg_t;

    localparam int unsigned ADDR_WIDTH = 5;

    localparam logic signed [31:0] MIN_VALUE_RST      = 32'sd0;
    localparam logic        [30:0] STEP_SIZE_RST      = 31'd65536;
    localparam logic        [15:0] N_STEPS_RST        = 16'd65535;
    localparam logic        [15:0] START_POSITION_RST = 16'd0;

    // step codes
    localparam logic signed [1:0] STEP_NONE = 2'sb00;
    localparam logic signed [1:0] STEP_UP   = 2'sb01;
    localparam logic signed [1:0] STEP_DOWN = 2'sb11;

    // accumulator values that mark a full detent
    localparam logic [7:0] SUM_DETENT_UP   = 8'h04;
    localparam logic [7:0] SUM_DETENT_DOWN = 8'hFC;

    // old pins, new pins -> increment; 8'h0E flags a bounce
    localparam logic [7:0] TRANS_TABLE [0:15] = '{
        8'h00, 8'hFF, 8'h01, 8'h0E, 8'h01, 8'h00, 8'h0E, 8'hFF,
        8'hFF, 8'h0E, 8'h00, 8'h01, 8'h0E, 8'h01, 8'hFF, 8'h00
    };

    typedef struct packed {
        logic signed [31:0] min_value;
        logic        [30:0] step_size;
        logic        [15:0] n_steps;
        logic               invert;
        logic               wrap_around;
        logic        [15:0] start_position;
        logic               load_start;
        logic        [15:0] load_value;
    } qdpc_cfg_t;

endpackage

/* sv/qdpc_regs.sv */
// ----------------------------------------------------------------------------
// qdpc_regs
// APB register file holding scale, range and direction settings
// ----------------------------------------------------------------------------
module qdpc_regs
    import qdpc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output qdpc_cfg_t             cfg
);

    logic signed [31:0] min_value_reg;
    logic        [30:0] step_size_reg;
    logic        [15:0] n_steps_reg;
    logic               invert_reg;
    logic               wrap_around_reg;
    logic        [15:0] start_position_reg;
    logic               wr_en;
    qdpc_reg_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = qdpc_reg_t'(paddr[ADDR_WIDTH-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg      <= MIN_VALUE_RST;
            step_size_reg      <= STEP_SIZE_RST;
            n_steps_reg        <= N_STEPS_RST;
            invert_reg         <= 1'b0;
            wrap_around_reg    <= 1'b0;
            start_position_reg <= START_POSITION_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MIN_VALUE:      min_value_reg      <= pwdata;
                REG_STEP_SIZE:      step_size_reg      <= pwdata[30:0];
                REG_N_STEPS:        n_steps_reg        <= pwdata[15:0];
                REG_INVERT:         invert_reg         <= pwdata[0];
                REG_WRAP_AROUND:    wrap_around_reg    <= pwdata[0];
                REG_START_POSITION: start_position_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MIN_VALUE:      prdata = min_value_reg;
            REG_STEP_SIZE:      prdata = {1'b0, step_size_reg};
            REG_N_STEPS:        prdata = {16'd0, n_steps_reg};
            REG_INVERT:         prdata = {31'd0, invert_reg};
            REG_WRAP_AROUND:    prdata = {31'd0, wrap_around_reg};
            REG_START_POSITION: prdata = {16'd0, start_position_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.min_value      = min_value_reg;
        cfg.step_size      = step_size_reg;
        cfg.n_steps        = n_steps_reg;
        cfg.invert         = invert_reg;
        cfg.wrap_around    = wrap_around_reg;
        cfg.start_position = start_position_reg;
        // counter load happens on the same edge as the register write
        cfg.load_start     = wr_en && (reg_sel == REG_START_POSITION);
        cfg.load_value     = pwdata[15:0];
    end

endmodule

/* sv/qdpc_track.sv */
// ----------------------------------------------------------------------------
// qdpc_track
// Transition decode, detent accumulator and clamped/wrapped position counter
// ----------------------------------------------------------------------------
`include "quadrature_detent_position_counter_top_macros.svh"

module qdpc_track
    import qdpc_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  qdpc_cfg_t                 cfg,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_pin_a,
    input  logic                      s_pin_b,
    output logic                      t_valid,
    input  logic                      t_ready,
    output logic signed [1:0]         t_step,
    output logic [POSITION_WIDTH-1:0] t_pos
);

    localparam int unsigned PW = POSITION_WIDTH;
    localparam int unsigned EW = PW + 16;

    logic [1:0]    last_pins_reg;
    logic [7:0]    sum_reg;
    logic [PW-1:0] pos_reg;
    logic          valid_reg;
    logic signed [1:0] step_reg;
    logic [PW-1:0] tpos_reg;

    logic [1:0]    pins_now;
    logic [7:0]    sum_add;
    logic [7:0]    sum_next;
    logic signed [1:0] dir_raw;
    logic signed [1:0] dir_next;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] top;
    logic [EW-1:0] nsteps_ext;
    logic [EW-1:0] mask_ext;
    logic [EW-1:0] load_ext;
    logic [EW-1:0] rst_ext;
    logic [PW:0]   pos_inc;
    logic [PW-1:0] pos_dec;
    logic          accept;

    assign s_ready = !valid_reg || t_ready;
    assign accept  = s_valid && s_ready;
    assign pins_now = {s_pin_a, s_pin_b};

    // highest position, n_steps saturated to the counter width
    assign nsteps_ext = {{PW{1'b0}}, cfg.n_steps};
    assign mask_ext   = {16'd0, {PW{1'b1}}};
    assign top        = (nsteps_ext > mask_ext) ? mask_ext[PW-1:0] : nsteps_ext[PW-1:0];
    assign load_ext   = {{PW{1'b0}}, cfg.load_value};
    assign rst_ext    = {{PW{1'b0}}, START_POSITION_RST};

    always_comb begin
        sum_add = sum_reg + TRANS_TABLE[{last_pins_reg, pins_now}];
        dir_raw = STEP_NONE;
        sum_next = sum_add;
        if (sum_add[1:0] == 2'b00) begin
            if (sum_add == SUM_DETENT_UP) begin
                dir_raw = STEP_UP;
            end else if (sum_add == SUM_DETENT_DOWN) begin
                dir_raw = STEP_DOWN;
            end
            sum_next = 8'd0;
        end
        dir_next = cfg.invert ? -dir_raw : dir_raw;
    end

    always_comb begin
        pos_inc = {1'b0, pos_reg} + {{PW{1'b0}}, 1'b1};
        pos_dec = pos_reg - {{(PW-1){1'b0}}, 1'b1};
        pos_next = pos_reg;
        unique case (dir_next)
            STEP_UP: begin
                if (pos_inc > {1'b0, top}) begin
                    pos_next = cfg.wrap_around ? '0 : top;
                end else begin
                    pos_next = pos_inc[PW-1:0];
                end
            end
            STEP_DOWN: begin
                if (pos_reg == '0) begin
                    pos_next = cfg.wrap_around ? top : '0;
                end else if (pos_dec > top) begin
                    pos_next = cfg.wrap_around ? '0 : top;
                end else begin
                    pos_next = pos_dec;
                end
            end
            default: pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg <= 2'b00;
            sum_reg       <= 8'd0;
            pos_reg       <= rst_ext[PW-1:0];
            valid_reg     <= 1'b0;
        end else begin
            if (cfg.load_start) begin
                pos_reg <= load_ext[PW-1:0];
            end else if (accept) begin
                pos_reg <= pos_next;
            end
            if (accept) begin
                last_pins_reg <= pins_now;
                sum_reg       <= sum_next;
                valid_reg     <= 1'b1;
            end else if (t_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            step_reg <= dir_next;
            tpos_reg <= pos_next;
        end
    end

    assign t_valid = valid_reg;
    assign t_step  = step_reg;
    assign t_pos   = tpos_reg;

    `QDPC_ASSERT_IMP(a_move_in_range, aclk, aresetn,
        accept && (dir_next != STEP_NONE), pos_next <= top,
        "position left the range after a move")
    `QDPC_ASSERT_NXT(a_hold_without_move, aclk, aresetn,
        accept && (dir_next == STEP_NONE) && !cfg.load_start, pos_reg == $past(pos_reg),
        "position changed without a detent")
    `QDPC_ASSERT_NXT(a_sum_cleared_on_detent, aclk, aresetn,
        accept && (dir_raw != STEP_NONE), sum_reg == 8'd0,
        "accumulator not cleared after a detent")

endmodule

/* sv/qdpc_scale.sv */
// ----------------------------------------------------------------------------
// qdpc_scale
// Position times step size, plus offset, saturated to signed Q16.16
// ----------------------------------------------------------------------------
`include "quadrature_detent_position_counter_top_macros.svh"

module qdpc_scale
    import qdpc_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  qdpc_cfg_t                 cfg,
    input  logic                      t_valid,
    output logic                      t_ready,
    input  logic signed [1:0]         t_step,
    input  logic [POSITION_WIDTH-1:0] t_pos,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [1:0]         m_step_taken,
    output logic [15:0]               m_position,
    output logic signed [31:0]        m_scaled_value
);

    localparam int unsigned PW = POSITION_WIDTH;
    localparam int unsigned MW = PW + 31;
    localparam int unsigned SW = MW + 2;

    logic              prod_valid_reg;
    logic [MW-1:0]     prod_reg;
    logic signed [1:0] prod_step_reg;
    logic [PW-1:0]     prod_pos_reg;

    logic              m_valid_reg;
    logic signed [1:0] m_step_reg;
    logic [15:0]       m_position_reg;
    logic signed [31:0] m_scaled_reg;

    logic              out_ready;
    logic              prod_load;
    logic              out_load;
    logic signed [SW-1:0] sum;
    logic [SW-32:0]    sum_top;
    logic signed [31:0] sat_value;
    logic [PW+15:0]    pos_ext;

    assign out_ready = !m_valid_reg || m_ready;
    assign t_ready   = !prod_valid_reg || out_ready;
    assign prod_load = t_valid && t_ready;
    assign out_load  = prod_valid_reg && out_ready;

    always_comb begin
        sum = $signed({2'b00, prod_reg}) + $signed({{(SW-32){cfg.min_value[31]}}, cfg.min_value});
        sum_top = sum[SW-1:31];
        // in range when all bits above bit 30 agree
        if ((sum_top == '0) || (sum_top == '1)) begin
            sat_value = sum[31:0];
        end else if (sum[SW-1]) begin
            sat_value = 32'sh8000_0000;
        end else begin
            sat_value = 32'sh7FFF_FFFF;
        end
    end

    assign pos_ext = {16'd0, prod_pos_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (prod_load) begin
                prod_valid_reg <= 1'b1;
            end else if (out_ready) begin
                prod_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_reg      <= MW'(t_pos) * MW'(cfg.step_size);
            prod_step_reg <= t_step;
            prod_pos_reg  <= t_pos;
        end
        if (out_load) begin
            m_step_reg     <= prod_step_reg;
            m_position_reg <= pos_ext[15:0];
            m_scaled_reg   <= sat_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_step_taken   = m_step_reg;
    assign m_position     = m_position_reg;
    assign m_scaled_value = m_scaled_reg;

    `QDPC_ASSERT_NXT(a_zero_product_is_offset, aclk, aresetn,
        out_load && (prod_reg == '0), m_scaled_value == $past(cfg.min_value),
        "zero product did not give the offset")
    `QDPC_ASSERT_NXT(a_no_overwrite, aclk, aresetn,
        prod_valid_reg && !out_ready, prod_valid_reg && $stable(prod_reg),
        "product stage overwritten while stalled")

endmodule

/* sv/quadrature_detent_position_counter_top.sv */
// pipeline: an accepted beat passes the track, product and output registers in turn
// throughput: one sample per cycle unless m_ready stalls the output; the position counter and detent
//   accumulator settle in the cycle of acceptance, the multiply has its own stage
// reset (aresetn low, synchronous): registers to defaults, pin history and
//   accumulator cleared, position loaded from the start_position default
// ----------------------------------------------------------------------------
// quadrature_detent_position_counter_top
// Quadrature detent decoder with scaled Q16.16 position output
// ----------------------------------------------------------------------------
module quadrature_detent_position_counter_top
    import qdpc_pkg::*;
#(
    parameter int unsigned POSITION_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_a,
    input  logic                  s_pin_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [1:0]     m_step_taken,
    output logic [15:0]           m_position,
    output logic signed [31:0]    m_scaled_value
);

    qdpc_cfg_t                 cfg;
    logic                      t_valid;
    logic                      t_ready;
    logic signed [1:0]         t_step;
    logic [POSITION_WIDTH-1:0] t_pos;

    qdpc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qdpc_track #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pin_a (s_pin_a),
        .s_pin_b (s_pin_b),
        .t_valid (t_valid),
        .t_ready (t_ready),
        .t_step  (t_step),
        .t_pos   (t_pos)
    );

    qdpc_scale #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .t_valid        (t_valid),
        .t_ready        (t_ready),
        .t_step         (t_step),
        .t_pos          (t_pos),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_taken   (m_step_taken),
        .m_position     (m_position),
        .m_scaled_value (m_scaled_value)
    );

endmodule
